>>> hw/rtl/bbd3_pkg.sv
package bbd3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Register field width and pixel widths are fixed by the stream format
  localparam int DIM_W = 11;
  localparam int PIX_W = 8;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int EXT_W = ((COL_W > ROW_W ? COL_W : ROW_W) + 1 > DIM_W) ?
                         (COL_W > ROW_W ? COL_W : ROW_W) + 1 : DIM_W;
  localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  localparam int RESET_DIM = 256;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'h00;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } action_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // One column shift travelling from the issue stage to the window stage
  typedef struct packed {
    logic             emit;
    logic             last;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
    logic             fg;
    logic [COL_W-1:0] addr;
  } col_op_t;

  // Map a raw register value onto 1..max_dim
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [EXT_W-1:0] max_dim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (EXT_W'(v) > max_dim) begin
      r = DIM_W'(max_dim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/binary_boundary_detect_3x3_unit.sv
// Flow: the item releasing a result goes through the window stage register, then
// the output register; pixel n+width+1 or a drain releases the result of pixel n.
// Throughput: one item per cycle unless the output stalls, set by the single read
// port of the column memory; a one-row frame holds its first drain for a pad shift.
// Reset: control, counters and window clear, width and height return to 256;
// the column memory is not cleared and needs no clearing pass.
module binary_boundary_detect_3x3_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [bbd3_pkg::PIX_W-1:0]  s_axis_tdata,   // [7:0] pixel_value
  input  logic [0:0]                  s_axis_tuser,   // [0] action
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bbd3_pkg::PIX_W-1:0]  m_axis_tdata,   // [7:0] edge_value
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [bbd3_pkg::DIM_W-1:0]  cfg_data
);

  localparam int COL_W = bbd3_pkg::COL_W;
  localparam int ROW_W = bbd3_pkg::ROW_W;
  localparam int EXT_W = bbd3_pkg::EXT_W;
  localparam int POS_W = bbd3_pkg::POS_W;
  localparam int DIM_W = bbd3_pkg::DIM_W;

  // Configuration
  logic [DIM_W-1:0]   eff_w;
  logic [DIM_W-1:0]   eff_h;
  logic [POS_W-1:0]   total;
  logic [DIM_W-1:0]   eff_w_next;
  logic [DIM_W-1:0]   eff_h_next;
  logic [2*DIM_W-1:0] total_prod;

  // Issue stage counters
  logic [COL_W-1:0]   col_in;
  logic [POS_W-1:0]   in_pos;
  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_col;
  logic               drain_started;

  // Window stage
  logic                 p1_valid;
  bbd3_pkg::col_op_t    p1;
  logic                 p1_go;
  logic                 adv_ok;
  logic [2:0]           win_left;
  logic [2:0]           win_mid;
  logic [2:0]           new_col;
  logic                 edge_hit;

  // Column memory: bit 1 = row two above, bit 0 = row above
  logic [1:0]           mem [bbd3_pkg::MAX_WIDTH];
  logic [1:0]           rd_raw;
  logic                 fwd_hit;
  logic [1:0]           fwd_data;
  logic [1:0]           rd_word;
  logic [1:0]           wr_data;

  // Issue decode
  logic               is_drain;
  logic               in_done;
  logic               pad_req;
  logic               accept;
  logic               issue;
  logic               emit;
  logic               last;
  logic               col_wrap;
  logic               out_col_wrap;
  bbd3_pkg::col_op_t  op;

  assign cfg_ready = 1'b1;

  always_comb begin
    eff_w_next = eff_w;
    eff_h_next = eff_h;
    if (cfg_index == bbd3_pkg::REG_IMAGE_WIDTH) begin
      eff_w_next = bbd3_pkg::clamp_dim(cfg_data, EXT_W'(bbd3_pkg::MAX_WIDTH));
    end else begin
      eff_h_next = bbd3_pkg::clamp_dim(cfg_data, EXT_W'(bbd3_pkg::MAX_HEIGHT));
    end
    total_prod = (2*DIM_W)'(eff_w_next) * (2*DIM_W)'(eff_h_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= DIM_W'(bbd3_pkg::RESET_DIM);
      eff_h <= DIM_W'(bbd3_pkg::RESET_DIM);
      total <= POS_W'(bbd3_pkg::RESET_DIM * bbd3_pkg::RESET_DIM);
    end else if (cfg_valid && cfg_ready) begin
      eff_w <= eff_w_next;
      eff_h <= eff_h_next;
      total <= POS_W'(total_prod);
    end
  end

  // Issue stage: decide what the item does and compute its border flags
  always_comb begin
    is_drain = (s_axis_tuser[0] == bbd3_pkg::ACT_DRAIN);
    in_done  = (in_pos >= total);
    adv_ok   = !p1_valid || p1_go;
    // a one-row frame needs one extra shift before its first drain
    pad_req  = s_axis_tvalid && is_drain && in_done &&
               (eff_h == DIM_W'(1)) && !drain_started;
    s_axis_tready = adv_ok && !pad_req;
    accept   = s_axis_tvalid && s_axis_tready;
    issue    = (pad_req && adv_ok) || (accept && (is_drain == in_done));
    emit     = accept && (is_drain == in_done) &&
               (is_drain || (in_pos >= POS_W'(eff_w) + POS_W'(1)));
    col_wrap     = (EXT_W'(col_in) + EXT_W'(1)) == EXT_W'(eff_w);
    out_col_wrap = (EXT_W'(out_col) + EXT_W'(1)) == EXT_W'(eff_w);
    last     = out_col_wrap && ((EXT_W'(out_row) + EXT_W'(1)) == EXT_W'(eff_h));

    op.emit     = emit;
    op.last     = last;
    op.top_ok   = (out_row != '0);
    op.bot_ok   = (EXT_W'(out_row) + EXT_W'(1)) < EXT_W'(eff_h);
    op.left_ok  = (out_col != '0);
    op.right_ok = !out_col_wrap;
    op.fg       = !is_drain && (s_axis_tdata != '0);
    op.addr     = col_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_in        <= '0;
      in_pos        <= '0;
      out_row       <= '0;
      out_col       <= '0;
      drain_started <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      col_in        <= '0;
      in_pos        <= '0;
      out_row       <= '0;
      out_col       <= '0;
      drain_started <= 1'b0;
    end else if (issue) begin
      if (emit && last) begin
        // frame done: restart all counters
        col_in        <= '0;
        in_pos        <= '0;
        out_row       <= '0;
        out_col       <= '0;
        drain_started <= 1'b0;
      end else begin
        col_in <= col_wrap ? '0 : col_in + COL_W'(1);
        if (accept && !is_drain) begin
          in_pos <= in_pos + POS_W'(1);
        end
        if (pad_req) begin
          drain_started <= 1'b1;
        end
        if (emit) begin
          if (out_col_wrap) begin
            out_col <= '0;
            out_row <= out_row + ROW_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end
    end
  end

  // Column memory read at issue, write back when the column leaves the window stage
  always_ff @(posedge clk) begin
    if (p1_go) begin
      mem[p1.addr] <= wr_data;
    end
    if (issue) begin
      rd_raw <= mem[col_in];
    end
  end

  // Forward a write to the column being read in the same cycle
  always_ff @(posedge clk) begin
    if (issue) begin
      fwd_hit  <= p1_go && (p1.addr == col_in);
      fwd_data <= wr_data;
    end
  end

  always_comb begin
    rd_word = fwd_hit ? fwd_data : rd_raw;
    new_col = {p1.fg, rd_word[0], rd_word[1]};   // [0] top, [1] mid, [2] bottom
    wr_data = {rd_word[0], p1.fg};
    p1_go   = p1_valid && (!p1.emit || !m_axis_tvalid || m_axis_tready);
    edge_hit = win_mid[1] && (
      (p1.top_ok && p1.left_ok  && !win_left[0]) ||
      (p1.top_ok                && !win_mid[0])  ||
      (p1.top_ok && p1.right_ok && !new_col[0])  ||
      (p1.left_ok               && !win_left[1]) ||
      (p1.right_ok              && !new_col[1])  ||
      (p1.bot_ok && p1.left_ok  && !win_left[2]) ||
      (p1.bot_ok                && !win_mid[2])  ||
      (p1.bot_ok && p1.right_ok && !new_col[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv_ok) begin
      p1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_ok && issue) begin
      p1 <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left <= '0;
      win_mid  <= '0;
    end else if (p1_go) begin
      win_left <= win_mid;
      win_mid  <= new_col;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (p1_go && p1.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_go && p1.emit) begin
      m_axis_tdata <= edge_hit ? bbd3_pkg::EDGE_ON : bbd3_pkg::EDGE_OFF;
      m_axis_tlast <= p1.last;
    end
  end

endmodule
